### rtl/rrc_pkg.sv
package rrc_pkg;

  localparam int NUM_TAPS           = 31;
  localparam int SAMPLES_PER_SYMBOL = 4;
  localparam int COEF_COUNT         = 31;

  localparam int SYM_W   = 4;
  localparam int SAMP_W  = 12;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = SAMP_W + COEF_W;
  localparam int ACC_W   = 29;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = ACC_W - FRAC_W;
  localparam int CALC_W  = QUO_W + 3;
  localparam int CODE_W  = 12;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = (SAMPLES_PER_SYMBOL > 1) ? $clog2(SAMPLES_PER_SYMBOL) : 1;

  localparam int MIDSCALE = 2151;
  localparam int CODE_MAX = 4095;

  localparam logic signed [SAMP_W-1:0] FULL_GAIN  = 12'sd1944;
  localparam logic signed [SAMP_W-1:0] HALF_GAIN  = 12'sd1360;
  localparam logic signed [SAMP_W-1:0] INNER_GAIN = 12'sd680;

  localparam logic signed [COEF_W-1:0] RRC_TAPS [COEF_COUNT] = '{
    16'sd150, -16'sd281, -16'sd668, -16'sd589, 16'sd98, 16'sd1042, 16'sd1507, 16'sd851,
    -16'sd891, -16'sd2765, -16'sd3230, -16'sd1048, 16'sd3886, 16'sd10177, 16'sd15446,
    16'sd17504,
    16'sd15446, 16'sd10177, 16'sd3886, -16'sd1048, -16'sd3230, -16'sd2765, -16'sd891,
    16'sd851, 16'sd1507, 16'sd1042, 16'sd98, -16'sd589, -16'sd668, -16'sd281, 16'sd150
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_BPSK  = 2'd0,
    MODE_QPSK  = 2'd1,
    MODE_8PSK  = 2'd2,
    MODE_16QAM = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [SAMP_W-1:0] i;
    logic signed [SAMP_W-1:0] q;
  } sample_t;

  typedef struct packed {
    logic    adv;
    sample_t x;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] i;
    logic signed [ACC_W-1:0] q;
  } acc_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input int k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    for (int j = 0; j < COEF_COUNT; j++) begin
      if (j == k) begin
        c = RRC_TAPS[j];
      end
    end
    return c;
  endfunction

  function automatic sample_t map_symbol(input mode_e mode, input logic [SYM_W-1:0] sym);
    sample_t s;
    s = '0;
    case (mode)
      MODE_BPSK: begin
        s.i = sym[0] ? -FULL_GAIN : FULL_GAIN;
        s.q = '0;
      end
      MODE_QPSK: begin
        s.i = (sym[1] ^ sym[0]) ? -FULL_GAIN : FULL_GAIN;
        s.q = sym[1] ? -FULL_GAIN : FULL_GAIN;
      end
      MODE_8PSK: begin
        case (sym[2:0])
          3'd0: begin s.i = FULL_GAIN;   s.q = '0;          end
          3'd1: begin s.i = HALF_GAIN;   s.q = HALF_GAIN;   end
          3'd2: begin s.i = '0;          s.q = FULL_GAIN;   end
          3'd3: begin s.i = -HALF_GAIN;  s.q = HALF_GAIN;   end
          3'd4: begin s.i = -FULL_GAIN;  s.q = '0;          end
          3'd5: begin s.i = -HALF_GAIN;  s.q = -HALF_GAIN;  end
          3'd6: begin s.i = '0;          s.q = -FULL_GAIN;  end
          default: begin s.i = HALF_GAIN; s.q = -HALF_GAIN; end
        endcase
      end
      MODE_16QAM: begin
        case (sym[1:0])
          2'd0:    s.i = -FULL_GAIN;
          2'd1:    s.i = -INNER_GAIN;
          2'd2:    s.i = INNER_GAIN;
          default: s.i = FULL_GAIN;
        endcase
        case (sym[3:2])
          2'd0:    s.q = FULL_GAIN;
          2'd1:    s.q = INNER_GAIN;
          2'd2:    s.q = -INNER_GAIN;
          default: s.q = -FULL_GAIN;
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  // divide by 2^16 toward zero, scale by 3, add midscale, saturate
  function automatic logic [CODE_W-1:0] to_code(input logic signed [ACC_W-1:0] acc);
    logic signed [QUO_W-1:0]  quo;
    logic signed [CALC_W-1:0] ext;
    logic signed [CALC_W-1:0] sum;
    logic [CODE_W-1:0]        code;
    quo = acc[ACC_W-1:FRAC_W];
    if (acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0)) begin
      quo = quo + QUO_W'(1);
    end
    ext = CALC_W'(quo);
    sum = ext + (ext <<< 1) + CALC_W'(MIDSCALE);
    if (sum[CALC_W-1]) begin
      code = '0;
    end else if (sum[CALC_W-2:CODE_W] != '0) begin
      code = CODE_W'(CODE_MAX);
    end else begin
      code = sum[CODE_W-1:0];
    end
    return code;
  endfunction

endpackage

### rtl/rrc_cell.sv
module rrc_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrc_pkg::cell_ctl_t                ctl_i,
  input  logic signed [rrc_pkg::COEF_W-1:0] coef_i,
  input  rrc_pkg::acc_t                     sum_i,
  output rrc_pkg::acc_t                     sum_o
);
  import rrc_pkg::*;

  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_q;
  acc_t                     sum_d;
  acc_t                     sum_q;

  always_comb begin
    prod_i  = PROD_W'(ctl_i.x.i) * PROD_W'(coef_i);
    prod_q  = PROD_W'(ctl_i.x.q) * PROD_W'(coef_i);
    sum_d.i = ACC_W'(prod_i) + sum_i.i;
    sum_d.q = ACC_W'(prod_q) + sum_i.q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.adv) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### rtl/rrc_chain.sv
module rrc_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrc_pkg::cell_ctl_t ctl_i,
  output rrc_pkg::acc_t      sum_o
);
  import rrc_pkg::*;

  // transposed form: each cell holds one partial sum and passes it toward cell 0
  acc_t link [NUM_TAPS+1];

  assign link[NUM_TAPS] = '0;

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    rrc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .coef_i (coef_at(k)),
      .sum_i  (link[k+1]),
      .sum_o  (link[k])
    );
  end

  assign sum_o = link[0];

endmodule

### rtl/rrc_pulse_shaping_modulator.sv
// channel   signals                                  transfer carries
// input     in_valid_i / in_ready_o                  symbol_i
// output    out_valid_o / out_ready_i                i_code_o, q_code_o, last_sample_o
// config    cfg_valid_i / cfg_ready_o                cfg_data_i (modulation mode)
//
// each symbol produces four samples, one per cycle while the output is not stalled;
// the rate is set by the cell chain advancing once per output sample.
// after its chain step a sample is converted to codes and registered in the output stage.
// reset clears the partial sums, the mode and all valid flags.
// output stalls back up through the sample stages and hold off the chain.
module rrc_pulse_shaping_modulator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rrc_pkg::MODE_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rrc_pkg::SYM_W-1:0]        symbol_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrc_pkg::CODE_W-1:0]       i_code_o,
  output logic [rrc_pkg::CODE_W-1:0]       q_code_o,
  output logic                             last_sample_o
);
  import rrc_pkg::*;

  localparam logic LAST_ON_ENTRY = (SAMPLES_PER_SYMBOL == 1);

  mode_e             mode_q;
  logic [CNT_W-1:0]  phase_d, phase_q;
  logic              acc_vld_q, acc_last_q;
  logic              out_vld_q, out_last_q;
  logic [CODE_W-1:0] out_i_q, out_q_q;
  logic              busy, out_free, acc_free, adv, last_d;
  cell_ctl_t         ctl;
  acc_t              chain_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BPSK;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  always_comb begin
    busy       = (phase_q != '0);
    out_free   = !out_vld_q || out_ready_i;
    acc_free   = !acc_vld_q || out_free;
    in_ready_o = !busy && acc_free;
    adv        = acc_free && (busy || in_valid_i);
    ctl.adv    = adv;
    ctl.x      = busy ? sample_t'('0) : map_symbol(mode_q, symbol_i);
    last_d     = busy ? (phase_q == CNT_W'(1)) : LAST_ON_ENTRY;
    phase_d    = phase_q;
    if (adv) begin
      phase_d = busy ? (phase_q - CNT_W'(1)) : CNT_W'(SAMPLES_PER_SYMBOL - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  rrc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sum_o  (chain_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q  <= 1'b0;
      acc_last_q <= 1'b0;
    end else if (acc_free) begin
      acc_vld_q  <= adv;
      acc_last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= acc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && acc_vld_q) begin
      out_i_q    <= to_code(chain_sum.i);
      out_q_q    <= to_code(chain_sum.q);
      out_last_q <= acc_last_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign i_code_o      = out_i_q;
  assign q_code_o      = out_q_q;
  assign last_sample_o = out_last_q;

endmodule
